// ===== rtl/egb_pkg.sv =====
// shared types, widths and the microcode table for the extended gcd block
package egb_pkg;

   // operand and coefficient widths
   localparam int OPERAND_WIDTH = 31;
   localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   // payload of one input beat
   typedef struct packed {
      logic [OPERAND_WIDTH-1:0] x_value;
      logic [OPERAND_WIDTH-1:0] y_value;
   } req_type;

   // payload of one result beat
   typedef struct packed {
      logic [OPERAND_WIDTH-1:0]      gcd_value;
      logic signed [COEF_WIDTH-1:0] coef_a;
      logic signed [COEF_WIDTH-1:0] coef_b;
   } rsp_type;

   // microprogram addresses
   typedef logic [2:0] step_addr_type;
   localparam step_addr_type STEP_IDLE   = 3'd0;
   localparam step_addr_type STEP_TEST   = 3'd1;
   localparam step_addr_type STEP_DINIT  = 3'd2;
   localparam step_addr_type STEP_DSTEP  = 3'd3;
   localparam step_addr_type STEP_UPDATE = 3'd4;
   localparam step_addr_type STEP_DONE   = 3'd5;

   // datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_DINIT,
      DP_DSTEP,
      DP_UPDATE
   } dp_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_REQ,
      COND_DIVISOR_ZERO,
      COND_COUNT_MORE,
      COND_RSP_TAKEN
   } cond_type;

   // one control word
   typedef struct packed {
      dp_op_type     op;
      cond_type      cond;
      step_addr_type target;
      logic          hold;
      logic          req_open;
      logic          rsp_show;
   } ctrl_word_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic divisor_zero;
      logic count_more;
   } dp_status_type;

   // microprogram rom
   function automatic ctrl_word_type ucode_rom(input step_addr_type addr);
      ctrl_word_type w;
      w = '{op: DP_NOP, cond: COND_NEVER, target: STEP_IDLE,
            hold: 1'b0, req_open: 1'b0, rsp_show: 1'b0};
      case (addr)
         STEP_IDLE: begin
            w.op       = DP_LOAD;
            w.cond     = COND_REQ;
            w.target   = STEP_TEST;
            w.hold     = 1'b1;
            w.req_open = 1'b1;
         end
         STEP_TEST: begin
            w.cond   = COND_DIVISOR_ZERO;
            w.target = STEP_DONE;
         end
         STEP_DINIT: begin
            w.op = DP_DINIT;
         end
         STEP_DSTEP: begin
            w.op     = DP_DSTEP;
            w.cond   = COND_COUNT_MORE;
            w.target = STEP_DSTEP;
         end
         STEP_UPDATE: begin
            w.op     = DP_UPDATE;
            w.cond   = COND_ALWAYS;
            w.target = STEP_TEST;
         end
         STEP_DONE: begin
            w.cond     = COND_RSP_TAKEN;
            w.target   = STEP_IDLE;
            w.hold     = 1'b1;
            w.rsp_show = 1'b1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/egb_seq.sv =====
// microcode sequencer: step counter, rom fetch and jump logic
module egb_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_stall,
   input  egb_pkg::dp_status_type status,
   output egb_pkg::dp_op_type     dp_op,
   output logic                  req_open,
   output logic                  rsp_show
);

   egb_pkg::step_addr_type step_ff, step_in;
   egb_pkg::ctrl_word_type word;
   logic                   take;

   // fetch the control word of the current step
   assign word     = egb_pkg::ucode_rom(step_ff);
   assign dp_op    = word.op;
   assign req_open = word.req_open;
   assign rsp_show = word.rsp_show;

   // evaluate the jump condition
   always_comb begin
      case (word.cond)
         egb_pkg::COND_NEVER:        take = 1'b0;
         egb_pkg::COND_ALWAYS:       take = 1'b1;
         egb_pkg::COND_REQ:          take = req_valid;
         egb_pkg::COND_DIVISOR_ZERO: take = status.divisor_zero;
         egb_pkg::COND_COUNT_MORE:   take = status.count_more;
         egb_pkg::COND_RSP_TAKEN:    take = !rsp_stall;
         default:                    take = 1'b1;
      endcase
   end

   // next step: jump, stay or advance
   always_comb begin
      if (take) begin
         step_in = word.target;
      end else if (word.hold) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + egb_pkg::step_addr_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= egb_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/egb_dp.sv =====
// datapath: remainders, coefficients, bit-serial divider and quotient products
module egb_dp (
   input  logic                  clock,
   input  egb_pkg::dp_op_type     dp_op,
   input  logic                  req_valid,
   input  egb_pkg::req_type       req_data,
   output egb_pkg::dp_status_type status,
   output egb_pkg::rsp_type       rsp_data
);

   localparam int W = egb_pkg::OPERAND_WIDTH;
   localparam int C = egb_pkg::COEF_WIDTH;
   localparam int N = egb_pkg::CNT_WIDTH;

   logic [W-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [W-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [C-1:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [C-1:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [C-1:0] ps_ff, ps_in, pt_ff, pt_in;
   logic [N-1:0] cnt_ff, cnt_in;

   logic [W:0]   partial;
   logic [W:0]   diff;
   logic         qbit;

   // one restoring division bit, quotient msb first
   assign partial = {rem_ff, dvd_ff[W-1]};
   assign diff    = partial - {1'b0, r1_ff};
   assign qbit    = !diff[W];

   // register updates per micro-operation
   always_comb begin
      r0_in  = r0_ff;
      r1_in  = r1_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      s0_in  = s0_ff;
      s1_in  = s1_ff;
      t0_in  = t0_ff;
      t1_in  = t1_ff;
      ps_in  = ps_ff;
      pt_in  = pt_ff;
      cnt_in = cnt_ff;
      case (dp_op)
         egb_pkg::DP_LOAD: begin
            if (req_valid) begin
               r0_in = req_data.x_value;
               r1_in = req_data.y_value;
               s0_in = C'(1);
               s1_in = '0;
               t0_in = '0;
               t1_in = C'(1);
            end
         end
         egb_pkg::DP_DINIT: begin
            rem_in = '0;
            dvd_in = r0_ff;
            ps_in  = '0;
            pt_in  = '0;
            cnt_in = N'(W - 1);
         end
         egb_pkg::DP_DSTEP: begin
            rem_in = qbit ? diff[W-1:0] : partial[W-1:0];
            dvd_in = {dvd_ff[W-2:0], 1'b0};
            // horner accumulation of quotient times coefficient
            ps_in  = {ps_ff[C-2:0], 1'b0} + (qbit ? s1_ff : '0);
            pt_in  = {pt_ff[C-2:0], 1'b0} + (qbit ? t1_ff : '0);
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - N'(1);
            end
         end
         egb_pkg::DP_UPDATE: begin
            r0_in = r1_ff;
            r1_in = rem_ff;
            s0_in = s1_ff;
            s1_in = s0_ff - ps_ff;
            t0_in = t1_ff;
            t1_in = t0_ff - pt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      s0_ff  <= s0_in;
      s1_ff  <= s1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      ps_ff  <= ps_in;
      pt_ff  <= pt_in;
      cnt_ff <= cnt_in;
   end

   // flags for the sequencer
   assign status.divisor_zero = (r1_ff == '0);
   assign status.count_more   = (cnt_ff != '0);

   // result held in the working registers once the divisor reaches zero
   assign rsp_data.gcd_value = r0_ff;
   assign rsp_data.coef_a    = s0_ff;
   assign rsp_data.coef_b    = t0_ff;

endmodule

// ===== rtl/extended_gcd_bezout.sv =====
// extended gcd with bezout coefficients, microcoded sequencer over a bit-serial datapath
// each input beat runs k euclid steps before its result beat is shown
// (k up to about 46 for 31-bit operands)
// each euclid step is one divider pass of OPERAND_WIDTH quotient bits in the shared datapath
// one item at a time: the next input beat is taken only after the result beat is accepted
// reset (synchronous) returns the sequencer to its idle step, data registers are not cleared
module extended_gcd_bezout (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  egb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output egb_pkg::rsp_type rsp_data
);

   egb_pkg::dp_op_type     dp_op;
   egb_pkg::dp_status_type status;
   logic                   req_open;
   logic                   rsp_show;

   // program sequencer
   egb_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .dp_op     (dp_op),
      .req_open  (req_open),
      .rsp_show  (rsp_show)
   );

   // arithmetic datapath
   egb_dp u_dp (
      .clock     (clock),
      .dp_op     (dp_op),
      .req_valid (req_valid),
      .req_data  (req_data),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // handshake from the control word
   assign req_stall = !req_open;
   assign rsp_valid = rsp_show;

endmodule
